// ===== rtl/hb64_pkg.sv =====
package hb64_pkg;

  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned MAXRES = 4;

  localparam logic [7:0] PAD_CHAR = 8'h3d;
  localparam logic [7:0] CASE_BIT = 8'h20;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_BAD = 2'd1,
    ST_ODD = 2'd2
  } status_t;

  typedef struct packed {
    logic       has_char;
    logic [7:0] b64_char;
    logic       end_of_run;
    status_t    status;
  } result_t;

  typedef struct packed {
    result_t [MAXRES-1:0] res;
    logic    [2:0]        cnt;
  } grp_t;

  function automatic logic [7:0] b64_char_of(input logic [5:0] idx);
    logic [7:0] x;
    x = {2'b00, idx};
    if (idx < 6'd26) begin
      return 8'h41 + x;
    end else if (idx < 6'd52) begin
      return 8'h61 + x - 8'd26;
    end else if (idx < 6'd62) begin
      return 8'h30 + x - 8'd52;
    end else if (idx == 6'd62) begin
      return 8'h2b;
    end else begin
      return 8'h2f;
    end
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] nib_of(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CASE_BIT;
    if (c >= 8'h30 && c <= 8'h39) begin
      return {1'b1, c[3:0]};
    end else if (lc >= 8'h61 && lc <= 8'h66) begin
      return {1'b1, lc[3:0] + 4'd9};
    end else begin
      return 5'd0;
    end
  endfunction

endpackage

// ===== rtl/hb64_if.sv =====
interface hb64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hex_char;
  logic       is_last;

  modport source (output valid, output hex_char, output is_last, input ready);
  modport sink (input valid, input hex_char, input is_last, output ready);
endinterface

interface hb64_out_if;
  logic       valid;
  logic       ready;
  logic       has_char;
  logic [7:0] b64_char;
  logic       end_of_run;
  logic [1:0] status;

  modport source (output valid, output has_char, output b64_char, output end_of_run,
                  output status, input ready);
  modport sink (input valid, input has_char, input b64_char, input end_of_run,
                input status, output ready);
endinterface

// ===== rtl/hb64_encode.sv =====
module hb64_encode
  import hb64_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  hb64_in_if.sink      in_chan,
  output logic         grp_valid,
  output grp_t         grp,
  input  logic         grp_ready
);

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_HELD  = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic [7:0] pbits_r, pbits_nxt;
  logic [1:0] pcnt_r, pcnt_nxt;
  logic       par_r, par_nxt;
  logic       bad_r, bad_nxt;
  logic       grp_valid_r;
  grp_t       grp_r, grp_nxt;
  logic       in_xfer;

  assign in_chan.ready = !grp_valid_r || grp_ready;
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign grp_valid     = grp_valid_r;
  assign grp           = grp_r;

  always_comb begin
    logic [7:0]  c;
    logic        last;
    logic [7:0]  dch [2];
    logic [1:0]  ndata;
    logic [4:0]  nv;
    logic [11:0] w;
    logic [2:0]  n;
    status_t     st;

    c         = in_chan.hex_char;
    last      = in_chan.is_last;
    dch[0]    = c;
    dch[1]    = c;
    ndata     = 2'd0;
    phase_nxt = PH_DATA;
    held_nxt  = held_r;
    pbits_nxt = pbits_r;
    pcnt_nxt  = pcnt_r;
    par_nxt   = par_r;
    bad_nxt   = bad_r;
    n         = 3'd0;
    st        = ST_OK;
    w         = 12'd0;
    nv        = 5'd0;
    for (int k = 0; k < MAXRES; k++) begin
      grp_nxt.res[k] = '{has_char: 1'b0, b64_char: 8'd0, end_of_run: 1'b0, status: ST_OK};
    end

    unique case (phase_r)
      PH_START: begin
        if (c == 8'h30 && !last) begin
          held_nxt  = c;
          phase_nxt = PH_HELD;
        end else begin
          ndata = 2'd1;
        end
      end
      PH_HELD: begin
        if (c != 8'h78 && c != 8'h58) begin
          dch[0] = held_r;
          ndata  = 2'd2;
        end
      end
      default: begin
        ndata = 2'd1;
      end
    endcase

    for (int k = 0; k < 2; k++) begin
      if (2'(k) < ndata) begin
        nv      = nib_of(dch[k]);
        par_nxt = !par_nxt;
        if (!nv[4]) begin
          bad_nxt = 1'b1;
        end
        if (!bad_nxt) begin
          if (pcnt_nxt < 2'd2) begin
            pbits_nxt = {pbits_nxt[3:0], nv[3:0]};
            pcnt_nxt  = pcnt_nxt + 2'd1;
          end else begin
            w = {pbits_nxt, nv[3:0]};
            grp_nxt.res[n[1:0]].has_char         = 1'b1;
            grp_nxt.res[n[1:0]].b64_char         = b64_char_of(w[11:6]);
            grp_nxt.res[n[1:0] + 2'd1].has_char  = 1'b1;
            grp_nxt.res[n[1:0] + 2'd1].b64_char  = b64_char_of(w[5:0]);
            n         = n + 3'd2;
            pbits_nxt = 8'd0;
            pcnt_nxt  = 2'd0;
          end
        end
      end
    end

    if (last) begin
      if (bad_nxt || par_nxt) begin
        n = 3'd0;
        grp_nxt.res[0].has_char = 1'b0;
        grp_nxt.res[0].b64_char = 8'd0;
        st = bad_nxt ? ST_BAD : ST_ODD;
      end else if (pcnt_nxt == 2'd2) begin
        grp_nxt.res[n[1:0]].has_char         = 1'b1;
        grp_nxt.res[n[1:0]].b64_char         = b64_char_of(pbits_nxt[7:2]);
        grp_nxt.res[n[1:0] + 2'd1].has_char  = 1'b1;
        grp_nxt.res[n[1:0] + 2'd1].b64_char  = b64_char_of({pbits_nxt[1:0], 4'd0});
        grp_nxt.res[n[1:0] + 2'd2].has_char  = 1'b1;
        grp_nxt.res[n[1:0] + 2'd2].b64_char  = PAD_CHAR;
        grp_nxt.res[n[1:0] + 2'd3].has_char  = 1'b1;
        grp_nxt.res[n[1:0] + 2'd3].b64_char  = PAD_CHAR;
        n = n + 3'd4;
      end else if (pcnt_nxt == 2'd1) begin
        grp_nxt.res[n[1:0]].has_char         = 1'b1;
        grp_nxt.res[n[1:0]].b64_char         = b64_char_of({pbits_nxt[3:0], 2'd0});
        grp_nxt.res[n[1:0] + 2'd1].has_char  = 1'b1;
        grp_nxt.res[n[1:0] + 2'd1].b64_char  = PAD_CHAR;
        n = n + 3'd2;
      end
      if (n == 3'd0) begin
        n = 3'd1;
      end
      grp_nxt.res[n[1:0] - 2'd1].end_of_run = 1'b1;
      grp_nxt.res[n[1:0] - 2'd1].status     = st;
      phase_nxt = PH_START;
      held_nxt  = 8'd0;
      pbits_nxt = 8'd0;
      pcnt_nxt  = 2'd0;
      par_nxt   = 1'b0;
      bad_nxt   = 1'b0;
    end
    grp_nxt.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      held_r      <= 8'd0;
      pbits_r     <= 8'd0;
      pcnt_r      <= 2'd0;
      par_r       <= 1'b0;
      bad_r       <= 1'b0;
      grp_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        held_r      <= held_nxt;
        pbits_r     <= pbits_nxt;
        pcnt_r      <= pcnt_nxt;
        par_r       <= par_nxt;
        bad_r       <= bad_nxt;
        grp_valid_r <= (grp_nxt.cnt != 3'd0);
        grp_r       <= grp_nxt;
      end else if (grp_ready) begin
        grp_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/hb64_queue.sv =====
module hb64_queue
  import hb64_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          grp_valid,
  input  grp_t          grp,
  output logic          grp_ready,
  hb64_out_if.source    out_chan
);

  result_t          mem [QDEPTH];
  logic [QAW-1:0]   wr_r, rd_r;
  logic [QAW:0]     count_r, count_nxt;
  logic [QAW:0]     free_slots;
  logic             push, pop;
  result_t          head;

  assign free_slots = (QAW+1)'(QDEPTH) - count_r;
  assign grp_ready  = free_slots >= (QAW+1)'(grp.cnt);
  assign push       = grp_valid && grp_ready;
  assign pop        = out_chan.valid && out_chan.ready;

  assign head                = mem[rd_r];
  assign out_chan.valid      = count_r != '0;
  assign out_chan.has_char   = head.has_char;
  assign out_chan.b64_char   = head.b64_char;
  assign out_chan.end_of_run = head.end_of_run;
  assign out_chan.status     = head.status;

  always_comb begin
    count_nxt = count_r;
    if (push) begin
      count_nxt = count_nxt + (QAW+1)'(grp.cnt);
    end
    if (pop) begin
      count_nxt = count_nxt - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      for (int k = 0; k < MAXRES; k++) begin
        if (3'(k) < grp.cnt) begin
          mem[wr_r + QAW'(k)] <= grp.res[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QAW'(grp.cnt);
      end
      if (pop) begin
        rd_r <= rd_r + QAW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/hex_to_base64_encoder.sv =====
// Streaming hex to base64 encoder. One ASCII hex character can be taken in
// every cycle; a transfer's results (zero to four base64 characters or
// status-only items) are computed in one pass, registered in the encoder's
// group register and then written to the queue. While the consumer is ready,
// results drain one per cycle through an eight-entry result queue, so the
// input only stalls when the queue has no room for the pending group, e.g.
// during the flush burst of a final item or when the consumer holds off
// ready. Status rides on the item with end_of_run set; characters sent
// before a bad or odd-length status should be discarded by the consumer.
module hex_to_base64_encoder
  import hb64_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  hb64_in_if.sink    in_chan,
  hb64_out_if.source out_chan
);

  logic grp_valid;
  logic grp_ready;
  grp_t grp;

  hb64_encode u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready)
  );

  hb64_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp_valid (grp_valid),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_chan  (out_chan)
  );

endmodule

// ===== sim/testbench.sv =====
module testbench;
  import hb64_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned TARGET_CHARS = 460;
  localparam logic [0:63][7:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  localparam result_t NO_RESULT  = '0;
  localparam result_t DONE_EMPTY = '{1'b0, 8'h00, 1'b1, ST_OK};
  localparam result_t DONE_BAD   = '{1'b0, 8'h00, 1'b1, ST_BAD};
  localparam result_t DONE_ODD   = '{1'b0, 8'h00, 1'b1, ST_ODD};

  typedef enum logic [1:0] {
    PH_FRESH,
    PH_HELD_ZERO,
    PH_DATA
  } prefix_phase_t;

  typedef struct {
    logic [7:0] ch;
    bit         last;
    bit         typed;
    result_t    want;
  } stim_row_t;

  // typed rows expect exactly the one result given
  stim_row_t directed_rows [26] = '{
    '{"0", 1'b0, 1'b0, NO_RESULT},
    '{"x", 1'b1, 1'b1, DONE_EMPTY},
    '{"0", 1'b1, 1'b1, DONE_ODD},
    '{"0", 1'b0, 1'b0, NO_RESULT},
    '{"X", 1'b0, 1'b0, NO_RESULT},
    '{"f", 1'b0, 1'b0, NO_RESULT},
    '{"F", 1'b0, 1'b0, NO_RESULT},
    '{"9", 1'b0, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, NO_RESULT},
    '{"1", 1'b0, 1'b0, NO_RESULT},
    '{"2", 1'b1, 1'b0, NO_RESULT},
    '{"0", 1'b0, 1'b0, NO_RESULT},
    '{"a", 1'b0, 1'b0, NO_RESULT},
    '{"B", 1'b0, 1'b0, NO_RESULT},
    '{"5", 1'b0, 1'b0, NO_RESULT},
    '{"7", 1'b1, 1'b1, DONE_ODD},
    '{"9", 1'b0, 1'b0, NO_RESULT},
    '{"A", 1'b1, 1'b0, NO_RESULT},
    '{"z", 1'b0, 1'b0, NO_RESULT},
    '{"1", 1'b0, 1'b0, NO_RESULT},
    '{"2", 1'b1, 1'b1, DONE_BAD},
    '{8'hff, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b1, DONE_BAD},
    '{"/", 1'b0, 1'b0, NO_RESULT},
    '{"@", 1'b1, 1'b1, DONE_BAD},
    '{"G", 1'b1, 1'b1, DONE_BAD}
  };

  logic clk;
  logic rst_n;

  hb64_in_if  in_chan();
  hb64_out_if out_chan();

  hex_to_base64_encoder DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // predictor state
  prefix_phase_t phase;
  logic [7:0]    held_zero;
  logic [7:0]    nib_pair;
  int unsigned   nib_count;
  bit            odd_chars;
  bit            bad_char;

  result_t predicted[$];
  result_t expected_b64[$];
  result_t want;

  int unsigned mismatches;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned results_checked;
  int unsigned quiet_cycles;
  bit          steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [7:0] folded;
    folded = c | 8'h20;
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if (folded >= "a" && folded <= "f") return {1'b1, 4'(folded - "a" + 8'd10)};
    return 5'd0;
  endfunction

  function void push_b64(logic [7:0] ch);
    result_t r;
    r = '{1'b1, ch, 1'b0, ST_OK};
    predicted.push_back(r);
  endfunction

  function void clear_encoder;
    phase     = PH_FRESH;
    held_zero = 8'h00;
    nib_pair  = 8'h00;
    nib_count = 0;
    odd_chars = 1'b0;
    bad_char  = 1'b0;
  endfunction

  function void absorb_digit(logic [7:0] c);
    logic [4:0]  v;
    logic [11:0] w;
    v = hex_value(c);
    odd_chars = ~odd_chars;
    if (!v[4]) bad_char = 1'b1;
    if (bad_char) return;
    if (nib_count < 2) begin
      nib_pair = {nib_pair[3:0], v[3:0]};
      nib_count++;
    end else begin
      w = {nib_pair, v[3:0]};
      push_b64(B64_ALPHABET[w[11:6]]);
      push_b64(B64_ALPHABET[w[5:0]]);
      nib_pair  = 8'h00;
      nib_count = 0;
    end
  endfunction

  function void predict_b64(logic [7:0] c, bit last);
    result_t tail;
    predicted.delete();
    case (phase)
      PH_FRESH: begin
        if (c == "0" && !last) begin
          held_zero = c;
          phase = PH_HELD_ZERO;
        end else begin
          phase = PH_DATA;
          absorb_digit(c);
        end
      end
      PH_HELD_ZERO: begin
        phase = PH_DATA;
        if (c != "x" && c != "X") begin
          absorb_digit(held_zero);
          absorb_digit(c);
        end
      end
      default: absorb_digit(c);
    endcase
    if (!last) return;
    if (bad_char) begin
      predicted.delete();
      predicted.push_back(DONE_BAD);
    end else if (odd_chars) begin
      predicted.delete();
      predicted.push_back(DONE_ODD);
    end else begin
      if (nib_count == 2) begin
        push_b64(B64_ALPHABET[nib_pair[7:2]]);
        push_b64(B64_ALPHABET[{nib_pair[1:0], 4'b0000}]);
        push_b64("=");
        push_b64("=");
      end else if (nib_count == 1) begin
        push_b64(B64_ALPHABET[{nib_pair[3:0], 2'b00}]);
        push_b64("=");
      end
      if (predicted.size() == 0) begin
        predicted.push_back(DONE_EMPTY);
      end else begin
        tail = predicted.pop_back();
        tail.end_of_run = 1'b1;
        tail.status = ST_OK;
        predicted.push_back(tail);
      end
    end
    clear_encoder();
  endfunction

  task automatic report_mismatch(string field, logic [7:0] expected, logic [7:0] got);
    $display("MISMATCH %s: expected %0h, got %0h (result %0d)", field, expected, got,
             results_checked);
    mismatches++;
  endtask

  task automatic send_char(logic [7:0] c, bit last, bit typed, result_t typed_want);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 23) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.hex_char <= c;
    in_chan.is_last  <= last;
    do @(posedge clk); while (!in_chan.ready);
    predict_b64(c, last);
    if (typed) begin
      expected_b64.push_back(typed_want);
    end else begin
      foreach (predicted[i]) expected_b64.push_back(predicted[i]);
    end
    chars_sent++;
    if (last) strings_sent++;
    steady = (chars_sent >= 300 && chars_sent < 380);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_b64.size() == 0) begin
        report_mismatch("unexpected result, b64_char", 8'h00, out_chan.b64_char);
      end else begin
        want = expected_b64.pop_front();
        if (out_chan.has_char !== want.has_char)
          report_mismatch("has_char", {7'b0, want.has_char}, {7'b0, out_chan.has_char});
        if (out_chan.b64_char !== want.b64_char)
          report_mismatch("b64_char", want.b64_char, out_chan.b64_char);
        if (out_chan.end_of_run !== want.end_of_run)
          report_mismatch("end_of_run", {7'b0, want.end_of_run}, {7'b0, out_chan.end_of_run});
        if (out_chan.status !== want.status)
          report_mismatch("status", {6'b0, want.status}, {6'b0, out_chan.status});
      end
      results_checked++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d cycles without a transfer", quiet_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // result side ready
  initial begin
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_chan.ready <= steady || ($urandom_range(99) >= 23);
    end
  end

  initial begin
    int unsigned r;
    int unsigned len;
    logic [3:0]  nib;
    logic [7:0]  text[$];
    bit          paused;

    in_chan.valid    = 1'b0;
    in_chan.hex_char = 8'h00;
    in_chan.is_last  = 1'b0;
    rst_n            = 1'b0;
    mismatches       = 0;
    chars_sent       = 0;
    strings_sent     = 0;
    results_checked  = 0;
    quiet_cycles     = 0;
    steady           = 1'b0;
    paused           = 1'b0;
    clear_encoder();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    while (chars_sent < TARGET_CHARS) begin
      if (!paused && chars_sent >= 230) begin
        // drain everything before going on
        paused = 1'b1;
        @(negedge clk);
        in_chan.valid <= 1'b0;
        while (expected_b64.size() != 0) @(negedge clk);
      end
      text.delete();
      r = $urandom_range(99);
      if (r < 6) begin
        len = $urandom_range(4, 1);
        repeat (len) text.push_back(8'($urandom_range(255)));
      end else begin
        if ($urandom_range(3) == 0) begin
          text.push_back("0");
          text.push_back($urandom_range(1) ? 8'("x") : 8'("X"));
          len = $urandom_range(12, 0);
        end else begin
          len = $urandom_range(12, 1);
        end
        if ($urandom_range(19) == 0) len = $urandom_range(40, 13);
        repeat (len) begin
          nib = 4'($urandom_range(15));
          if (nib < 10) text.push_back(8'("0" + nib));
          else text.push_back(8'(($urandom_range(1) ? "A" : "a") + nib - 10));
        end
        // corrupt one character
        if (r < 18) text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
      end
      foreach (text[i]) send_char(text[i], i == text.size() - 1, 1'b0, NO_RESULT);
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (expected_b64.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("sent %0d hex strings (%0d characters, prefixes, bad bytes, odd lengths)",
             strings_sent, chars_sent);
    $display("checked %0d base64 results field by field", results_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== hex_to_base64_encoder.f =====
rtl/hb64_pkg.sv
rtl/hb64_if.sv
rtl/hb64_encode.sv
rtl/hb64_queue.sv
rtl/hex_to_base64_encoder.sv
sim/testbench.sv
